### hdl/tliu_pkg.sv
package tliu_pkg;

    localparam int TLIU_ENTRIES  = 64;
    localparam int TLIU_CHANNELS = 4;
    localparam int DIV_STEPS     = 64;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_ZERO_WIDTH = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         channel;
        logic signed [31:0] key;
        logic signed [31:0] value_real;
        logic signed [31:0] value_imag;
    } t_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] result_real;
        logic signed [31:0] result_imag;
        logic [5:0]         segment;
    } t_result;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    clr_cnt;
        logic    wr_ent;
        logic    rd_en;
        logic    shift_lo;
        logic    found;
        logic    mul;
        logic    div_step;
        logic    fin;
        logic    part;
        logic    set_status;
        t_status status;
        logic    seg_cnt;
        logic    seg_idx;
        logic    take_hi;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       gt;
        logic       dk_zero;
    } t_stat;

endpackage

### hdl/tliu_dp.sv
module tliu_dp #(
    parameter int ENTRIES  = 64,
    parameter int CHANNELS = 4,
    parameter int IW       = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tliu_pkg::t_item   i_item,
    input  tliu_pkg::t_cmd    i_cmd,
    input  logic [IW-1:0]     i_rd_idx,
    input  logic [IW-1:0]     i_seg_idx,
    output tliu_pkg::t_stat   o_stat,
    output logic [IW:0]       o_cnt,
    output tliu_pkg::t_result o_result
);
    import tliu_pkg::*;

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [40:0] QLIM = 41'h100_0000_0000;

    t_entry r_mem [DEPTH];
    logic [IW:0] r_cnt [CHANNELS];

    logic [1:0]         r_op;
    logic [CW-1:0]      r_ch;
    logic signed [31:0] r_qkey;
    t_entry             r_new;
    t_entry             r_rd, r_lo, r_hi;
    t_result            r_res;

    logic [63:0] r_dvd;
    logic [31:0] r_dmag;
    logic [31:0] r_rem;
    logic [40:0] r_q;
    logic        r_ovf;
    logic        r_neg;

    logic [AW-1:0]      addr;
    logic [IW:0]        cnt;
    logic signed [32:0] dk, tk, dv;
    logic signed [31:0] vlo, vhi;
    logic [31:0]        dk_mag, tk_mag, dv_mag;
    logic [32:0]        rr;
    logic               take;
    logic [40:0]        qc;
    logic signed [42:0] sum;
    logic signed [31:0] sat;

    assign cnt = r_cnt[r_ch];
    assign o_cnt = cnt;
    assign addr = AW'(r_ch) * AW'(ENTRIES)
                + AW'(i_cmd.wr_ent ? cnt[IW-1:0] : i_rd_idx);

    assign dk = 33'(r_hi.key) - 33'(r_lo.key);
    assign tk = 33'(r_qkey) - 33'(r_lo.key);
    assign vlo = i_cmd.part ? r_lo.im : r_lo.re;
    assign vhi = i_cmd.part ? r_hi.im : r_hi.re;
    assign dv = 33'(vhi) - 33'(vlo);
    assign dk_mag = dk[32] ? 32'(-dk) : dk[31:0];
    assign tk_mag = tk[32] ? 32'(-tk) : tk[31:0];
    assign dv_mag = dv[32] ? 32'(-dv) : dv[31:0];

    assign rr = {r_rem, r_dvd[63]};
    assign take = rr >= {1'b0, r_dmag};

    assign qc = (r_ovf || r_q > QLIM) ? QLIM : r_q;
    assign sum = r_neg ? 43'(vlo) - 43'(qc) : 43'(vlo) + 43'(qc);
    always_comb begin
        if (sum > 43'sd2147483647) begin
            sat = 32'sh7fff_ffff;
        end else if (sum < -43'sd2147483648) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = sum[31:0];
        end
    end

    assign o_stat.op = r_op;
    assign o_stat.gt = r_rd.key > r_qkey;
    assign o_stat.dk_zero = (dk == '0);
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ent) begin
            r_mem[addr] <= r_new;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c] <= '0;
            end
        end else if (i_cmd.clr_cnt) begin
            r_cnt[r_ch] <= '0;
        end else if (i_cmd.wr_ent) begin
            r_cnt[r_ch] <= cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_item.operation;
            r_ch       <= CW'(i_item.channel % CHANNELS);
            r_qkey     <= i_item.key;
            r_new.key  <= i_item.key;
            r_new.re   <= i_item.value_real;
            r_new.im   <= i_item.value_imag;
            r_res      <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_res.status <= i_cmd.status;
            end
            if (i_cmd.seg_cnt) begin
                r_res.segment <= 6'(cnt);
            end
            if (i_cmd.seg_idx) begin
                r_res.segment <= 6'(i_seg_idx);
            end
            if (i_cmd.take_hi) begin
                r_res.result_real <= r_hi.re;
                r_res.result_imag <= r_hi.im;
            end
            if (i_cmd.fin) begin
                if (i_cmd.part) begin
                    r_res.result_imag <= sat;
                end else begin
                    r_res.result_real <= sat;
                end
            end
        end
        if (i_cmd.shift_lo) begin
            r_lo <= r_rd;
        end
        if (i_cmd.found) begin
            r_hi <= r_rd;
        end
        if (i_cmd.mul) begin
            r_dvd  <= dv_mag * tk_mag;
            r_dmag <= dk_mag;
            r_neg  <= dv[32] ^ tk[32] ^ dk[32];
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= take ? 32'(rr - {1'b0, r_dmag}) : rr[31:0];
            r_q   <= {r_q[39:0], take};
            r_ovf <= r_ovf | r_q[40];
        end
    end

endmodule

### hdl/tliu_ctrl.sv
module tliu_ctrl #(
    parameter int ENTRIES = 64,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tliu_pkg::t_stat i_stat,
    input  logic [IW:0]     i_cnt,
    output tliu_pkg::t_cmd  o_cmd,
    output logic [IW-1:0]   o_rd_idx,
    output logic [IW-1:0]   o_seg_idx,
    output logic            o_busy,
    output logic            o_valid
);
    import tliu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_WALK, S_CHECK, S_MUL, S_DIV, S_FIN, S_DONE
    } t_state;

    t_state      r_state, n_state;
    logic [IW:0] r_idx;
    logic        r_dval;
    logic [IW-1:0] r_didx;
    logic [5:0]  r_step;
    logic        r_part;
    logic        r_valid;

    logic found, last, rd_go;

    assign rd_go = (r_idx < i_cnt);
    assign found = r_dval && (r_didx != '0) && i_stat.gt;
    assign last  = r_dval && ({1'b0, r_didx} == i_cnt - 1'b1);
    assign o_rd_idx  = r_idx[IW-1:0];
    assign o_seg_idx = r_didx;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.part = r_part;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (t_op'(i_stat.op))
                    OP_CLEAR:  o_cmd.clr_cnt = 1'b1;
                    OP_APPEND: begin
                        if (i_cnt >= (IW+1)'(ENTRIES)) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.wr_ent = 1'b1;
                            o_cmd.seg_cnt = 1'b1;
                        end
                    end
                    OP_QUERY: begin
                        if (i_cnt == '0) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status = ST_EMPTY;
                        end else if (i_cnt == (IW+1)'(1)) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status = ST_NOT_FOUND;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                if (found) begin
                    o_cmd.found = 1'b1;
                    o_cmd.seg_idx = 1'b1;
                    n_state = S_CHECK;
                end else if (last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd.shift_lo = r_dval;
                    o_cmd.rd_en = rd_go;
                end
            end
            S_CHECK: begin
                if (i_stat.dk_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = ST_ZERO_WIDTH;
                    o_cmd.take_hi = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == 6'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = r_part ? S_DONE : S_MUL;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_dval  <= 1'b0;
            r_didx  <= '0;
            r_step  <= '0;
            r_part  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (n_state == S_DONE);
            if (r_state == S_DECODE) begin
                r_idx  <= '0;
                r_dval <= 1'b0;
                r_part <= 1'b0;
            end
            if (r_state == S_WALK) begin
                r_dval <= rd_go;
                r_didx <= r_idx[IW-1:0];
                r_idx  <= r_idx + 1'b1;
            end
            if (r_state == S_MUL) begin
                r_step <= '0;
            end
            if (r_state == S_DIV) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == S_FIN) begin
                r_part <= 1'b1;
            end
        end
    end

endmodule

### hdl/table_linear_interpolation_unit.sv
// Piecewise linear interpolation over per-channel tables of complex entries.
// An item is transferred in when start is high while busy is low; it either
// clears a channel, appends an entry, queries a key or does nothing. Every
// item produces exactly one result, shown on o_result for a single cycle
// while o_valid is high; the receiver cannot hold a result off and must
// take it then. Clear, append and trivial queries pass from the decode state
// straight to the done state, where o_valid is high; the next transfer can
// follow once busy is low again. A query walks the channel's table one entry
// per cycle through the entry memory's registered read port, and an
// interpolating query then runs the bit-serial divider twice (real and
// imaginary). Busy stays high until the result cycle, so items are handled
// one at a time.
// Reset clears the per-channel entry counts and the controller; the entry
// memory itself is not cleared, since only entries below a channel's count
// are ever read.
module table_linear_interpolation_unit #(
    parameter int ENTRIES  = tliu_pkg::TLIU_ENTRIES,
    parameter int CHANNELS = tliu_pkg::TLIU_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tliu_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_valid,
    output tliu_pkg::t_result o_result
);
    import tliu_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    t_cmd          cmd;
    t_stat         stat;
    logic [IW:0]   cnt;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] seg_idx;

    // The controller sequences each item; the datapath holds the tables,
    // the multiplier and the serial divider.
    tliu_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_stat    (stat),
        .i_cnt     (cnt),
        .o_cmd     (cmd),
        .o_rd_idx  (rd_idx),
        .o_seg_idx (seg_idx),
        .o_busy    (busy),
        .o_valid   (o_valid)
    );

    tliu_dp #(
        .ENTRIES  (ENTRIES),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cmd     (cmd),
        .i_rd_idx  (rd_idx),
        .i_seg_idx (seg_idx),
        .o_stat    (stat),
        .o_cnt     (cnt),
        .o_result  (o_result)
    );

    // A result is only shown while an item is still in flight.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe outside of an item");

    // Each result lasts exactly one cycle.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    // A transfer in makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item transfer not taken");

    // An empty channel reports zero values.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_EMPTY) |->
        (o_result.result_real == '0 && o_result.result_imag == '0))
        else $error("empty channel result carries data");

endmodule
